>>> rtl/core/wsd_pkg.sv
// Shared types and constants of the WebSocket frame deframer.
`default_nettype none

package wsd_pkg;

  // Result kinds carried on the output tuser.
  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_EMPTY   = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  // Output tdata: payload byte, FIN, opcode, padded to whole bytes.
  localparam int unsigned OUT_TDATA_W = 16;

  typedef struct packed {
    logic       valid;
    logic [1:0] kind;
    logic [7:0] payload_byte;
    logic       final_fragment;
    logic [3:0] frame_opcode;
    logic       last_of_frame;
  } wsd_result_t;

endpackage

`default_nettype wire

>>> rtl/core/wsd_parser.sv
// Frame header parser, length counter and payload unmasking for the deframer.
`default_nettype none

module wsd_parser (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              step,
  input  wire logic [7:0]        data_byte,
  output wsd_pkg::wsd_result_t   res
);

  localparam logic [2:0] PH_HDR0    = 3'd0;
  localparam logic [2:0] PH_HDR1    = 3'd1;
  localparam logic [2:0] PH_EXTLEN  = 3'd2;
  localparam logic [2:0] PH_KEY     = 3'd3;
  localparam logic [2:0] PH_PAYLOAD = 3'd4;
  localparam logic [2:0] PH_HALT    = 3'd5;

  logic [2:0]  phase, phase_next;
  logic [3:0]  length_bytes_left, length_bytes_left_next;
  logic [63:0] bytes_remaining, bytes_remaining_next;
  logic [31:0] mask_key, mask_key_next;
  logic [1:0]  key_index, key_index_next;
  logic        fin_flag, fin_flag_next;
  logic [3:0]  opcode_held, opcode_held_next;

  logic [7:0]  key_byte;

  // Key byte 0 sits in the top byte of the key register.
  assign key_byte = mask_key[{~key_index, 3'b000} +: 8];

  always_comb begin
    phase_next             = phase;
    length_bytes_left_next = length_bytes_left;
    bytes_remaining_next   = bytes_remaining;
    mask_key_next          = mask_key;
    key_index_next         = key_index;
    fin_flag_next          = fin_flag;
    opcode_held_next       = opcode_held;

    res                = '0;
    res.final_fragment = fin_flag;
    res.frame_opcode   = opcode_held;

    unique case (phase)
      PH_HDR0: begin
        fin_flag_next    = data_byte[7];
        opcode_held_next = data_byte[3:0];
        phase_next       = PH_HDR1;
      end
      PH_HDR1: begin
        if (!data_byte[7]) begin
          phase_next = PH_HALT;
          res.valid  = 1'b1;
          res.kind   = wsd_pkg::KIND_ERROR;
        end else begin
          key_index_next = 2'd0;
          mask_key_next  = '0;
          if (data_byte[6:0] == 7'd126) begin
            bytes_remaining_next   = '0;
            length_bytes_left_next = 4'd2;
            phase_next             = PH_EXTLEN;
          end else if (data_byte[6:0] == 7'd127) begin
            bytes_remaining_next   = '0;
            length_bytes_left_next = 4'd8;
            phase_next             = PH_EXTLEN;
          end else begin
            bytes_remaining_next   = {57'd0, data_byte[6:0]};
            length_bytes_left_next = 4'd0;
            phase_next             = PH_KEY;
          end
        end
      end
      PH_EXTLEN: begin
        bytes_remaining_next   = {bytes_remaining[55:0], data_byte};
        length_bytes_left_next = length_bytes_left - 4'd1;
        if (length_bytes_left == 4'd1) begin
          key_index_next = 2'd0;
          phase_next     = PH_KEY;
        end
      end
      PH_KEY: begin
        mask_key_next  = {mask_key[23:0], data_byte};
        key_index_next = key_index + 2'd1;
        if (key_index == 2'd3) begin
          if (bytes_remaining == 64'd0) begin
            phase_next        = PH_HDR0;
            res.valid         = 1'b1;
            res.kind          = wsd_pkg::KIND_EMPTY;
            res.last_of_frame = 1'b1;
          end else begin
            phase_next = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        key_index_next       = key_index + 2'd1;
        bytes_remaining_next = bytes_remaining - 64'd1;
        res.valid            = 1'b1;
        res.kind             = wsd_pkg::KIND_PAYLOAD;
        res.payload_byte     = data_byte ^ key_byte;
        // Compare before the decrement so the two run side by side.
        res.last_of_frame    = (bytes_remaining == 64'd1);
        if (bytes_remaining == 64'd1) begin
          phase_next = PH_HDR0;
        end
      end
      PH_HALT: begin
        phase_next = PH_HALT;
      end
      default: begin
        phase_next = PH_HALT;
      end
    endcase

    if (!step) begin
      res.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_HDR0;
      length_bytes_left <= '0;
      bytes_remaining   <= '0;
      mask_key          <= '0;
      key_index         <= '0;
      fin_flag          <= 1'b0;
      opcode_held       <= '0;
    end else if (step) begin
      phase             <= phase_next;
      length_bytes_left <= length_bytes_left_next;
      bytes_remaining   <= bytes_remaining_next;
      mask_key          <= mask_key_next;
      key_index         <= key_index_next;
      fin_flag          <= fin_flag_next;
      opcode_held       <= opcode_held_next;
    end
  end

  // Once halted the parser never leaves the halt phase and stays silent.
  a_halt_silent: assert property (@(posedge clk) disable iff (rst)
    phase == PH_HALT |-> !res.valid)
    else $error("result produced after protocol error");

  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    phase == PH_HALT |=> phase == PH_HALT)
    else $error("left halt phase without reset");

  a_error_halts: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.kind == wsd_pkg::KIND_ERROR |=> phase == PH_HALT)
    else $error("error result not followed by halt");

  a_empty_frame: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.kind == wsd_pkg::KIND_EMPTY |->
      res.last_of_frame && bytes_remaining == 64'd0)
    else $error("empty-frame result with nonzero length");

endmodule

`default_nettype wire

>>> rtl/core/websocket_frame_deframer_unit.sv
// Top level of the WebSocket client-to-server frame deframer.
//
// The deframer takes a client-to-server WebSocket byte stream, one byte per
// input item, parses each frame header (FIN, opcode, mask bit, 7-bit length
// with optional 16-bit or 64-bit big-endian extension, 4-byte masking key)
// and emits every payload byte unmasked, flagging the final byte of each
// frame on tlast. A frame with zero payload length gives a single empty-frame
// item with tlast set. A frame without the mask bit gives one protocol error
// item, after which every further byte is consumed and dropped until reset.
// Header bytes produce no output item, except the error and empty-frame
// items. The block accepts one byte every cycle, sustained, whatever the
// frame layout, as long as the output is taken; a byte is caught in an input
// register and passes through the parser logic into the result register,
// from which its result is offered. The rate is set by the parser step,
// whose longest path is the 64-bit length down-counter and its compare.
// While a result waits on a stalled output, the input register still takes
// one more byte; input ready then stays low until that result is taken.
// Input ready follows output ready in the same cycle when both registers are
// full.
`default_nettype none

module websocket_frame_deframer_unit (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // Input stream.
  input  wire logic                             s_tvalid,
  output      logic                             s_tready,
  input  wire logic [7:0]                       s_tdata,   // [7:0] data_byte
  // Result stream.
  output      logic                             m_tvalid,
  input  wire logic                             m_tready,
  output      logic [wsd_pkg::OUT_TDATA_W-1:0]  m_tdata,   // [7:0] payload_byte,
                                                           // [8] final_fragment,
                                                           // [12:9] frame_opcode
  output      logic [1:0]                       m_tuser,   // [1:0] kind
  output      logic                             m_tlast    // last_of_frame
);

  logic                 in_valid;
  logic [7:0]           in_byte;
  logic                 advance;
  wsd_pkg::wsd_result_t res;

  logic [7:0]           out_payload;
  logic                 out_fin;
  logic [3:0]           out_opcode;
  logic [1:0]           out_kind;
  logic                 out_last;

  // The held byte moves through the parser whenever the result register is
  // free or is being emptied in this same cycle.
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
  end

  wsd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .data_byte (in_byte),
    .res       (res)
  );

  // Result register. Header bytes load it only with error or empty-frame items.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= res.valid;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.valid) begin
      out_payload <= res.payload_byte;
      out_fin     <= res.final_fragment;
      out_opcode  <= res.frame_opcode;
      out_kind    <= res.kind;
      out_last    <= res.last_of_frame;
    end
  end

  assign m_tdata = {3'd0, out_opcode, out_fin, out_payload};
  assign m_tuser = out_kind;
  assign m_tlast = out_last;

endmodule

`default_nettype wire
